// File: rtl/core/dpp_pkg.sv
`default_nettype none
package dpp_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = 16;
  localparam int PRIO_W  = 7;
  localparam int TIME_W  = 32;
  localparam int STATE_W = 3;
  localparam int KIND_W  = 3;
  localparam int NUM_W   = CNT_W + 4;
  localparam int DEN_W   = CNT_W + 1;

  localparam logic [PRIO_W-1:0] PRIO_MAX     = PRIO_W'(100);
  localparam logic [PRIO_W-1:0] PRIO_DEFAULT = PRIO_W'(60);
  localparam logic [3:0]        NICE_MID     = 4'd5;
  localparam logic [3:0]        NICE_SCALE   = 4'd10;
  localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

  typedef enum logic [STATE_W-1:0] {
    ST_UNUSED   = 3'd0,
    ST_USED     = 3'd1,
    ST_SLEEPING = 3'd2,
    ST_RUNNABLE = 3'd3,
    ST_RUNNING  = 3'd4,
    ST_ZOMBIE   = 3'd5
  } slot_state_t;

  typedef enum logic [KIND_W-1:0] {
    K_TICK      = 3'd0,
    K_PICK      = 3'd1,
    K_SET_STATE = 3'd2,
    K_SET_PRIO  = 3'd3,
    K_CREATE    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_TICK_RD,
    S_TICK_WR,
    S_PK_RD,
    S_PK_LD,
    S_PK_DIV,
    S_PK_CMP,
    S_PK_END,
    S_OP_RD,
    S_OP_WR,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic idx_inc;
    logic rd_slot;
    logic tick_wr;
    logic tick_clk;
    logic pk_load;
    logic div_step;
    logic pk_cmp;
    logic pk_commit;
    logic op_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idx_last;
    logic              runnable;
    logic              div_last;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/dpp_ctrl.sv
`default_nettype none
module dpp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire dpp_pkg::sts_t sts,
  output dpp_pkg::cmd_t      cmd
);

  dpp_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpp_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = dpp_pkg::S_DISP;
      end
      dpp_pkg::S_DISP: begin
        priority case (sts.kind)
          dpp_pkg::K_TICK:      state_nxt = dpp_pkg::S_TICK_RD;
          dpp_pkg::K_PICK:      state_nxt = dpp_pkg::S_PK_RD;
          dpp_pkg::K_SET_STATE,
          dpp_pkg::K_SET_PRIO,
          dpp_pkg::K_CREATE:    state_nxt = dpp_pkg::S_OP_RD;
          default:              state_nxt = dpp_pkg::S_DONE;
        endcase
      end
      dpp_pkg::S_TICK_RD: state_nxt = dpp_pkg::S_TICK_WR;
      dpp_pkg::S_TICK_WR: begin
        state_nxt = sts.idx_last ? dpp_pkg::S_DONE : dpp_pkg::S_TICK_RD;
      end
      dpp_pkg::S_PK_RD: state_nxt = dpp_pkg::S_PK_LD;
      dpp_pkg::S_PK_LD: begin
        if (sts.runnable) begin
          state_nxt = dpp_pkg::S_PK_DIV;
        end else begin
          state_nxt = sts.idx_last ? dpp_pkg::S_PK_END : dpp_pkg::S_PK_RD;
        end
      end
      dpp_pkg::S_PK_DIV: begin
        if (sts.div_last) state_nxt = dpp_pkg::S_PK_CMP;
      end
      dpp_pkg::S_PK_CMP: begin
        state_nxt = sts.idx_last ? dpp_pkg::S_PK_END : dpp_pkg::S_PK_RD;
      end
      dpp_pkg::S_PK_END: state_nxt = dpp_pkg::S_DONE;
      dpp_pkg::S_OP_RD:  state_nxt = dpp_pkg::S_OP_WR;
      dpp_pkg::S_OP_WR:  state_nxt = dpp_pkg::S_DONE;
      dpp_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = dpp_pkg::S_IDLE;
      end
      default: state_nxt = dpp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dpp_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      dpp_pkg::S_DISP:    cmd.idx_clr = 1'b1;
      dpp_pkg::S_TICK_RD: ;
      dpp_pkg::S_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      dpp_pkg::S_PK_RD: ;
      dpp_pkg::S_PK_LD: begin
        cmd.pk_load = sts.runnable;
        cmd.idx_inc = !sts.runnable;
      end
      dpp_pkg::S_PK_DIV: cmd.div_step = 1'b1;
      dpp_pkg::S_PK_CMP: begin
        cmd.pk_cmp  = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      dpp_pkg::S_PK_END: cmd.pk_commit = 1'b1;
      dpp_pkg::S_OP_RD:  cmd.rd_slot = 1'b1;
      dpp_pkg::S_OP_WR:  cmd.op_wr = 1'b1;
      dpp_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
        cmd.tick_clk = sts.out_free && (sts.kind == dpp_pkg::K_TICK);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/dpp_dp.sv
`default_nettype none
module dpp_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [23:0]   in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [23:0]        out_tdata,
  input  wire logic          cfg_we,
  input  wire logic [6:0]    cfg_wdata,
  input  wire dpp_pkg::cmd_t cmd,
  output dpp_pkg::sts_t      sts
);

  localparam int SW = dpp_pkg::SLOT_W;
  localparam int CW = dpp_pkg::CNT_W;
  localparam int PW = dpp_pkg::PRIO_W;
  localparam int TW = dpp_pkg::TIME_W;
  localparam int NW = dpp_pkg::NUM_W;
  localparam int DW = dpp_pkg::DEN_W;

  logic [dpp_pkg::KIND_W-1:0]  kind_r;
  logic [SW-1:0]               slot_r;
  logic [dpp_pkg::STATE_W-1:0] nstate_r;
  logic [PW-1:0]               preq_r;
  logic [PW-1:0]               dflt_r;
  logic [TW-1:0]               tick_clock_r;
  logic [SW-1:0]               idx_r;

  logic [dpp_pkg::STATE_W-1:0] st_mem    [dpp_pkg::SLOTS];
  logic [PW-1:0]               sp_mem    [dpp_pkg::SLOTS];
  logic [CW-1:0]               run_mem   [dpp_pkg::SLOTS];
  logic [CW-1:0]               slp_mem   [dpp_pkg::SLOTS];
  logic [CW-1:0]               pick_mem  [dpp_pkg::SLOTS];
  logic [TW-1:0]               birth_mem [dpp_pkg::SLOTS];
  logic [dpp_pkg::SLOTS-1:0]   valid_r;

  logic [SW-1:0]               rd_addr, addr_q_r, wr_addr;
  logic [dpp_pkg::STATE_W-1:0] st_q_r, st_rd;
  logic                        vq_r;
  logic [PW-1:0]               sp_q_r;
  logic [CW-1:0]               run_q_r, slp_q_r, pick_q_r;
  logic [TW-1:0]               birth_q_r;

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [3:0]    q_r;
  logic [1:0]    step_r;
  logic          zero_r;
  logic [PW-1:0] c_sp_r;
  logic [CW-1:0] c_pick_r;
  logic [TW-1:0] c_birth_r;
  logic [SW-1:0] c_slot_r;

  logic          have_r;
  logic [SW-1:0] best_r;
  logic [PW-1:0] best_dp_r;
  logic [CW-1:0] best_pick_r;
  logic [TW-1:0] best_birth_r;
  logic [PW-1:0] oldp_r;
  logic          out_valid_r;
  logic [23:0]   out_data_r;
  logic [23:0]   out_data_nxt;

  logic [NW-1:0] den_sh;
  logic [3:0]    nice;
  logic [PW:0]   v5, vsub;
  logic [PW-1:0] dp;
  logic          take;
  logic          st_we, sp_we, run_we, slp_we, pick_we, birth_we;
  logic [dpp_pkg::STATE_W-1:0] st_wd;
  logic [PW-1:0] sp_wd;
  logic [CW-1:0] run_wd, slp_wd, pick_wd;
  logic [PW-1:0] preq_clamp, dflt_clamp;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == dpp_pkg::CNT_MAX) ? v : v + CW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r       <= dpp_pkg::PRIO_DEFAULT;
      tick_clock_r <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      have_r       <= 1'b0;
    end else begin
      if (cfg_we) dflt_r <= cfg_wdata;
      if (cmd.tick_clk) tick_clock_r <= tick_clock_r + TW'(1);
      if (st_we) valid_r[wr_addr] <= 1'b1;
      if (cmd.idx_clr) have_r <= 1'b0;
      else if (cmd.pk_cmp && take) have_r <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_tdata[2:0];
      slot_r   <= in_tdata[8:3];
      nstate_r <= in_tdata[11:9];
      preq_r   <= in_tdata[18:12];
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + SW'(1);
  end

  assign rd_addr = cmd.rd_slot ? slot_r : idx_r;
  assign st_rd   = vq_r ? st_q_r : dpp_pkg::ST_UNUSED;

  always_ff @(posedge clk) begin
    addr_q_r  <= rd_addr;
    vq_r      <= valid_r[rd_addr];
    st_q_r    <= st_mem[rd_addr];
    sp_q_r    <= sp_mem[rd_addr];
    run_q_r   <= run_mem[rd_addr];
    slp_q_r   <= slp_mem[rd_addr];
    pick_q_r  <= pick_mem[rd_addr];
    birth_q_r <= birth_mem[rd_addr];
    if (st_we)    st_mem[wr_addr]    <= st_wd;
    if (sp_we)    sp_mem[wr_addr]    <= sp_wd;
    if (run_we)   run_mem[wr_addr]   <= run_wd;
    if (slp_we)   slp_mem[wr_addr]   <= slp_wd;
    if (pick_we)  pick_mem[wr_addr]  <= pick_wd;
    if (birth_we) birth_mem[wr_addr] <= tick_clock_r;
  end

  assign preq_clamp = (preq_r > dpp_pkg::PRIO_MAX) ? dpp_pkg::PRIO_MAX : preq_r;
  assign dflt_clamp = (dflt_r > dpp_pkg::PRIO_MAX) ? dpp_pkg::PRIO_MAX : dflt_r;

  always_comb begin
    wr_addr  = cmd.pk_commit ? best_r : (cmd.tick_wr ? addr_q_r : slot_r);
    st_we    = 1'b0;
    sp_we    = 1'b0;
    run_we   = 1'b0;
    slp_we   = 1'b0;
    pick_we  = 1'b0;
    birth_we = 1'b0;
    st_wd    = nstate_r;
    sp_wd    = preq_clamp;
    run_wd   = '0;
    slp_wd   = '0;
    pick_wd  = '0;
    if (cmd.tick_wr) begin
      run_we = (st_rd == dpp_pkg::ST_RUNNING);
      slp_we = (st_rd == dpp_pkg::ST_SLEEPING);
      run_wd = sat_inc(run_q_r);
      slp_wd = sat_inc(slp_q_r);
    end
    if (cmd.pk_commit && have_r) begin
      st_we   = 1'b1;
      st_wd   = dpp_pkg::ST_RUNNING;
      run_we  = 1'b1;
      slp_we  = 1'b1;
      pick_we = 1'b1;
      pick_wd = sat_inc(best_pick_r);
    end
    if (cmd.op_wr) begin
      priority case (kind_r)
        dpp_pkg::K_SET_STATE: st_we = (nstate_r <= dpp_pkg::ST_ZOMBIE);
        dpp_pkg::K_SET_PRIO: begin
          sp_we  = 1'b1;
          run_we = 1'b1;
          slp_we = 1'b1;
        end
        dpp_pkg::K_CREATE: begin
          st_we    = 1'b1;
          st_wd    = dpp_pkg::ST_USED;
          sp_we    = 1'b1;
          sp_wd    = dflt_clamp;
          run_we   = 1'b1;
          slp_we   = 1'b1;
          pick_we  = 1'b1;
          birth_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign den_sh = NW'(den_r) << step_r;

  always_ff @(posedge clk) begin
    if (cmd.pk_load) begin
      num_r     <= NW'(slp_q_r) * NW'(dpp_pkg::NICE_SCALE);
      den_r     <= DW'(slp_q_r) + DW'(run_q_r);
      zero_r    <= (slp_q_r == '0) && (run_q_r == '0);
      q_r       <= '0;
      step_r    <= 2'd3;
      c_sp_r    <= sp_q_r;
      c_pick_r  <= pick_q_r;
      c_birth_r <= birth_q_r;
      c_slot_r  <= addr_q_r;
    end else if (cmd.div_step) begin
      if (num_r >= den_sh) begin
        num_r     <= num_r - den_sh;
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 2'd1;
    end
    if (cmd.pk_cmp && take) begin
      best_r       <= c_slot_r;
      best_dp_r    <= dp;
      best_pick_r  <= c_pick_r;
      best_birth_r <= c_birth_r;
    end
    if (cmd.op_wr) oldp_r <= sp_q_r;
  end

  always_comb begin
    nice = zero_r ? dpp_pkg::NICE_MID : q_r;
    v5   = {1'b0, c_sp_r} + (PW+1)'(dpp_pkg::NICE_MID);
    vsub = v5 - (PW+1)'(nice);
    if (v5 <= (PW+1)'(nice)) dp = '0;
    else if (vsub > (PW+1)'(dpp_pkg::PRIO_MAX)) dp = dpp_pkg::PRIO_MAX;
    else dp = vsub[PW-1:0];
    if (!have_r) take = 1'b1;
    else if (dp != best_dp_r) take = dp < best_dp_r;
    else if (c_pick_r != best_pick_r) take = c_pick_r < best_pick_r;
    else take = c_birth_r < best_birth_r;
  end

  always_comb begin
    out_data_nxt = '0;
    if (kind_r == dpp_pkg::K_PICK) begin
      out_data_nxt[0]    = have_r;
      out_data_nxt[6:1]  = have_r ? best_r : slot_r;
      out_data_nxt[13:7] = have_r ? best_dp_r : '0;
    end else begin
      out_data_nxt[0]     = 1'b1;
      out_data_nxt[6:1]   = slot_r;
      out_data_nxt[20:14] = (kind_r == dpp_pkg::K_SET_PRIO) ? oldp_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.kind     = kind_r;
  assign sts.idx_last = (idx_r == SW'(dpp_pkg::SLOTS - 1));
  assign sts.runnable = (st_rd == dpp_pkg::ST_RUNNABLE);
  assign sts.div_last = (step_r == 2'd0);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule
`default_nettype wire

// File: rtl/core/dynamic_priority_process_picker.sv
// Process picker over a table of 64 slots, one word in and one word out per item.
// The input channel carries a kind (tick, pick, set state, set priority, create),
// a slot, a new state and a requested priority. The result channel returns found,
// the chosen or echoed slot, the dynamic priority of a picked slot and the static
// priority that a set priority item replaced.
// Items are handled one at a time; in_tready is high only while the block is idle.
// A tick walks every slot with a read and a write. A pick walks every slot; for
// a runnable slot a 4-step restoring divider forms the niceness before the slot
// is compared with the best one so far. Set state, set priority and create read
// the slot and then write it. The slot tables have one read and one write port.
// Reset empties the table, clears the tick clock and loads the default priority 60.
// A result waits in an output register while out_tready is low; the block finishes
// its item and accepts no new one until that register can be loaded.
// The user must write the default priority through cfg_we and cfg_wdata only
// while idle; the block itself does not enforce this.
`default_nettype none
module dynamic_priority_process_picker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // kind[2:0], slot[8:3], new_state[11:9], priority_req[18:12]
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // found[0], chosen_slot[6:1], dyn_priority[13:7], prev_priority[20:14]
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);

  dpp_pkg::cmd_t cmd;
  dpp_pkg::sts_t sts;

  dpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

// File: rtl/core/dpp_checker.sv
`default_nettype none
module dpp_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new word taken while an item is in progress");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[20:7] == 14'd0))
    else $error("failed pick carries priorities");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind dynamic_priority_process_picker dpp_props u_dpp_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
